// ===== rtl/core/afb_pkg.sv =====
`timescale 1ns / 1ps

package afb_pkg;

  localparam logic [7:0] StartByte   = 8'h7E;
  localparam logic [7:0] ZeroByte    = 8'h00;
  localparam logic [7:0] FullByte    = 8'hFF;
  localparam logic [7:0] AddrLoByte  = 8'hFE;
  localparam logic [7:0] RemoteOpt   = 8'h02;
  localparam logic [7:0] TxLenBase   = 8'd14;
  localparam logic [7:0] LocalLen    = 8'd4;
  localparam logic [7:0] RemoteLen   = 8'd15;
  localparam int unsigned IdxW       = 5;

  localparam logic [1:0] CmdTransmit = 2'd0;
  localparam logic [1:0] CmdLocalAt  = 2'd1;
  localparam logic [1:0] CmdRemoteAt = 2'd2;

  localparam logic [1:0] RegTypeTransmit = 2'd0;
  localparam logic [1:0] RegTypeLocalAt  = 2'd1;
  localparam logic [1:0] RegTypeRemoteAt = 2'd2;

  typedef enum logic [2:0] {
    JobReject,
    JobData,
    JobTransmit,
    JobLocalAt,
    JobRemoteAt
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] dest_address;
    logic [15:0] at_command;
    logic [6:0]  payload_length;
    logic [7:0]  data_byte;
  } afb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [7:0] frame_id;
    logic       rejected;
  } afb_out_t;

  typedef struct packed {
    job_kind_e   kind;
    logic        closes;
    logic [63:0] dest;
    logic [15:0] atc;
    logic [7:0]  dbyte;
    logic [7:0]  len;
    logic [7:0]  ftype;
    logic [7:0]  id;
  } afb_job_t;

  typedef struct packed {
    logic last;
    logic counts;
    logic clear;
  } afb_ctrl_t;

endpackage

// ===== rtl/core/afb_byte_gen.sv =====
`timescale 1ns / 1ps

module afb_byte_gen (
  input  afb_pkg::afb_job_t          job_i,
  input  logic [afb_pkg::IdxW-1:0]   idx_i,
  input  logic [7:0]                 sum_i,
  output afb_pkg::afb_out_t          out_o,
  output afb_pkg::afb_ctrl_t         ctrl_o
);
  import afb_pkg::*;

  logic [7:0] byte_w;
  logic       chk_w;
  logic       last_w;
  logic [2:0] dsel_w;
  logic [7:0] dest_w;
  logic [7:0] chk_val_w;

  assign dsel_w    = 3'(5'd12 - idx_i);
  assign dest_w    = job_i.dest[{dsel_w, 3'b000} +: 8];
  assign chk_val_w = FullByte - sum_i;

  always_comb begin
    byte_w = ZeroByte;
    chk_w  = 1'b0;
    last_w = 1'b0;
    case (job_i.kind)
      JobReject: begin
        last_w = 1'b1;
      end
      JobData: begin
        if (idx_i == 5'd0) begin
          byte_w = job_i.dbyte;
          last_w = !job_i.closes;
        end else begin
          chk_w  = 1'b1;
          last_w = 1'b1;
        end
      end
      default: begin
        case (idx_i)
          5'd0: byte_w = StartByte;
          5'd1: byte_w = ZeroByte;
          5'd2: byte_w = job_i.len;
          5'd3: byte_w = job_i.ftype;
          5'd4: byte_w = job_i.id;
          default: begin
            if (job_i.kind == JobLocalAt) begin
              case (idx_i)
                5'd5:    byte_w = job_i.atc[15:8];
                5'd6:    byte_w = job_i.atc[7:0];
                default: begin
                  chk_w  = 1'b1;
                  last_w = 1'b1;
                end
              endcase
            end else if (idx_i <= 5'd12) begin
              byte_w = dest_w;
            end else begin
              case (idx_i)
                5'd13: byte_w = FullByte;
                5'd14: byte_w = AddrLoByte;
                5'd15: byte_w = (job_i.kind == JobRemoteAt) ? RemoteOpt : ZeroByte;
                5'd16: begin
                  byte_w = (job_i.kind == JobRemoteAt) ? job_i.atc[15:8] : ZeroByte;
                  last_w = (job_i.kind == JobTransmit) && !job_i.closes;
                end
                5'd17: begin
                  if (job_i.kind == JobRemoteAt) begin
                    byte_w = job_i.atc[7:0];
                  end else begin
                    chk_w  = 1'b1;
                    last_w = 1'b1;
                  end
                end
                default: begin
                  chk_w  = 1'b1;
                  last_w = 1'b1;
                end
              endcase
            end
          end
        endcase
      end
    endcase
  end

  always_comb begin
    out_o.frame_byte = chk_w ? chk_val_w : byte_w;
    out_o.frame_end  = chk_w;
    out_o.frame_id   = (job_i.kind == JobReject) ? ZeroByte : job_i.id;
    out_o.rejected   = (job_i.kind == JobReject);
    ctrl_o.last      = last_w;
    ctrl_o.clear     = chk_w ||
                       ((job_i.kind != JobReject) && (job_i.kind != JobData) &&
                        (idx_i == 5'd0));
    ctrl_o.counts    = !chk_w && (job_i.kind != JobReject) &&
                       ((job_i.kind == JobData) || (idx_i >= 5'd3));
  end

endmodule

// ===== rtl/core/api_frame_builder.sv =====
`timescale 1ns / 1ps

// Radio-module API frame builder. Items enter on the input channel (valid and
// stall) and each one turns into a run of frame bytes on the output channel.
// A transmit request header gives 17 bytes, or 18 when its payload is empty; a
// local AT command gives 8 bytes and a remote AT command 19 bytes. Each payload
// byte item gives one byte, and the last one of a frame gives two, the second
// being the checksum. A refused item gives a single byte marked rejected.
// While the output does not stall, the sequencer emits one byte per cycle and
// payload items pass at one per cycle; an item holds the input until its last
// byte is emitted. Each item is registered before its first byte. The next item
// is accepted in the cycle that the last byte of the current one is registered.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits. Frame type codes are written on the configuration port,
// which is always ready. Reset clears the frame id counter, the open frame
// and the output valid flag, and restores the default type codes.
module api_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  afb_pkg::afb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output afb_pkg::afb_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import afb_pkg::*;

  logic [7:0]      type_tx_q, type_lat_q, type_rat_q;
  logic [7:0]      id_cnt_q;
  logic            open_q;
  logic [6:0]      left_q;
  logic [7:0]      open_id_q;
  logic [7:0]      sum_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  afb_job_t        job_q, job_d;
  logic            out_valid_q;
  afb_out_t        out_q;

  afb_out_t  gen_out;
  afb_ctrl_t gen_ctrl;
  logic      adv, done, acc;
  logic      oversize;

  afb_byte_gen u_gen (
    .job_i  (job_q),
    .idx_i  (idx_q),
    .sum_i  (sum_q),
    .out_o  (gen_out),
    .ctrl_o (gen_ctrl)
  );

  assign adv         = busy_q && (!out_valid_q || !out_stall_i);
  assign done        = adv && gen_ctrl.last;
  assign in_stall_o  = busy_q && !done;
  assign acc         = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign oversize    = {1'b0, in_data_i.payload_length} > 8'(MAX_PAYLOAD);

  always_comb begin
    job_d        = job_q;
    job_d.dest   = in_data_i.dest_address;
    job_d.atc    = in_data_i.at_command;
    job_d.dbyte  = in_data_i.data_byte;
    job_d.closes = 1'b0;
    job_d.id     = id_cnt_q;
    job_d.len    = LocalLen;
    job_d.ftype  = type_lat_q;
    if (in_data_i.cmd != CmdTransmit && in_data_i.cmd != CmdLocalAt &&
        in_data_i.cmd != CmdRemoteAt) begin
      job_d.kind = JobReject;
    end else if (open_q) begin
      job_d.kind   = (in_data_i.cmd == CmdTransmit) ? JobData : JobReject;
      job_d.closes = (left_q == 7'd1);
      job_d.id     = open_id_q;
    end else if (in_data_i.cmd == CmdTransmit) begin
      job_d.kind   = oversize ? JobReject : JobTransmit;
      job_d.closes = (in_data_i.payload_length == 7'd0);
      job_d.len    = {1'b0, in_data_i.payload_length} + TxLenBase;
      job_d.ftype  = type_tx_q;
    end else if (in_data_i.cmd == CmdLocalAt) begin
      job_d.kind = JobLocalAt;
    end else begin
      job_d.kind  = JobRemoteAt;
      job_d.len   = RemoteLen;
      job_d.ftype = type_rat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_tx_q   <= 8'd16;
      type_lat_q  <= 8'd8;
      type_rat_q  <= 8'd23;
      id_cnt_q    <= '0;
      open_q      <= 1'b0;
      left_q      <= '0;
      open_id_q   <= '0;
      sum_q       <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTypeTransmit: type_tx_q  <= cfg_data_i;
          RegTypeLocalAt:  type_lat_q <= cfg_data_i;
          RegTypeRemoteAt: type_rat_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        case (job_d.kind)
          JobData: begin
            left_q <= left_q - 7'd1;
            if (job_d.closes) begin
              open_q <= 1'b0;
            end
          end
          JobTransmit: begin
            id_cnt_q <= id_cnt_q + 8'd1;
            if (!job_d.closes) begin
              open_q    <= 1'b1;
              left_q    <= in_data_i.payload_length;
              open_id_q <= id_cnt_q;
            end
          end
          JobLocalAt, JobRemoteAt: begin
            id_cnt_q <= id_cnt_q + 8'd1;
          end
          default: ;
        endcase
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + 5'd1;
      end
      if (adv) begin
        if (gen_ctrl.clear) begin
          sum_q <= '0;
        end else if (gen_ctrl.counts) begin
          sum_q <= sum_q + gen_out.frame_byte;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      job_q <= job_d;
    end
    if (adv) begin
      out_q <= gen_out;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && out_stall_i) |=> (busy_q && $stable(idx_q)))
    else $error("Sequencer moved while the output was stalled.");

  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != 7'd0))
    else $error("Transmit frame open with no payload bytes left.");

  a_end_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> !out_data_o.rejected)
    else $error("Checksum byte marked as rejected.");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (busy_q && (idx_q == '0)))
    else $error("Accepted transaction did not start the sequencer.");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import afb_pkg::*;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned QuietLimit = 2000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  afb_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  afb_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  api_frame_builder #(
    .MAX_PAYLOAD(MaxPayload)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Expected frame bytes and the builder state that produces them.
  afb_out_t   frame_q[$];
  logic [7:0] type_tx_m, type_lat_m, type_rat_m;
  logic [7:0] id_count_m, sum_m, open_id_m;
  logic [6:0] left_m;
  bit         open_m;

  int unsigned send_gap_pct, recv_gap_pct;
  int unsigned items_sent, bytes_checked, refusals_expected;
  int unsigned fail_count;
  afb_out_t    want;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (recv_gap_pct != 0) && ($urandom_range(99) < recv_gap_pct);
  end

  function automatic void push_byte(logic [7:0] b, bit summed, bit last, logic [7:0] id);
    afb_out_t r;
    if (summed) sum_m = sum_m + b;
    r.frame_byte = b;
    r.frame_end  = last;
    r.frame_id   = id;
    r.rejected   = 1'b0;
    frame_q.push_back(r);
  endfunction

  function automatic void push_checksum(logic [7:0] id);
    push_byte(FullByte - sum_m, 1'b0, 1'b1, id);
    sum_m = ZeroByte;
  endfunction

  function automatic void push_refusal();
    afb_out_t r;
    r = '0;
    r.rejected = 1'b1;
    frame_q.push_back(r);
    refusals_expected++;
  endfunction

  function automatic void push_header(logic [7:0] len, logic [7:0] ftype, logic [7:0] id);
    sum_m = ZeroByte;
    push_byte(StartByte, 1'b0, 1'b0, id);
    push_byte(ZeroByte, 1'b0, 1'b0, id);
    push_byte(len, 1'b0, 1'b0, id);
    push_byte(ftype, 1'b1, 1'b0, id);
    push_byte(id, 1'b1, 1'b0, id);
  endfunction

  function automatic void push_address(logic [63:0] dest, logic [7:0] id);
    for (int k = 7; k >= 0; k--) push_byte(dest[8*k +: 8], 1'b1, 1'b0, id);
    push_byte(FullByte, 1'b1, 1'b0, id);
    push_byte(AddrLoByte, 1'b1, 1'b0, id);
  endfunction

  function automatic void predict_frame_bytes(afb_in_t it);
    logic [7:0] id;
    id = id_count_m;
    if (it.cmd == CmdUnused) begin
      push_refusal();
    end else if (open_m) begin
      if (it.cmd != CmdTransmit) begin
        push_refusal();
      end else begin
        push_byte(it.data_byte, 1'b1, 1'b0, open_id_m);
        left_m = left_m - 7'd1;
        if (left_m == 7'd0) begin
          open_m = 1'b0;
          push_checksum(open_id_m);
        end
      end
    end else if (it.cmd == CmdTransmit) begin
      if (it.payload_length > MaxPayload) begin
        push_refusal();
      end else begin
        push_header({1'b0, it.payload_length} + TxLenBase, type_tx_m, id);
        push_address(it.dest_address, id);
        push_byte(ZeroByte, 1'b1, 1'b0, id);
        push_byte(ZeroByte, 1'b1, 1'b0, id);
        id_count_m = id_count_m + 8'd1;
        if (it.payload_length == 7'd0) begin
          push_checksum(id);
        end else begin
          open_m    = 1'b1;
          left_m    = it.payload_length;
          open_id_m = id;
        end
      end
    end else begin
      if (it.cmd == CmdLocalAt) begin
        push_header(LocalLen, type_lat_m, id);
      end else begin
        push_header(RemoteLen, type_rat_m, id);
        push_address(it.dest_address, id);
        push_byte(RemoteOpt, 1'b1, 1'b0, id);
      end
      push_byte(it.at_command[15:8], 1'b1, 1'b0, id);
      push_byte(it.at_command[7:0], 1'b1, 1'b0, id);
      push_checksum(id);
      id_count_m = id_count_m + 8'd1;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        $display("%0t: byte with nothing expected, expected none, actual %h",
                 $time, out_data_o);
        fail_count++;
      end else begin
        want = frame_q.pop_front();
        check_field("frame_byte", want.frame_byte, out_data_o.frame_byte);
        check_field("frame_end", 8'(want.frame_end), 8'(out_data_o.frame_end));
        check_field("frame_id", want.frame_id, out_data_o.frame_id);
        check_field("rejected", 8'(want.rejected), 8'(out_data_o.rejected));
        bytes_checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) break;
    end
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("status: fail");
    $finish;
  end

  function automatic afb_in_t make_item(logic [1:0] cmd, logic [63:0] dest,
                                        logic [15:0] atc, logic [6:0] plen,
                                        logic [7:0] dbyte);
    afb_in_t it;
    it.cmd            = cmd;
    it.dest_address   = dest;
    it.at_command     = atc;
    it.payload_length = plen;
    it.data_byte      = dbyte;
    return it;
  endfunction

  function automatic afb_in_t random_item();
    afb_in_t     it;
    int unsigned pick;
    int unsigned size_pick;
    it = make_item(CmdTransmit, {$urandom, $urandom}, 16'($urandom), 7'($urandom),
                   8'($urandom));
    pick      = $urandom_range(99);
    size_pick = $urandom_range(99);
    if (open_m) begin
      if (pick >= 92) it.cmd = 2'($urandom_range(3, 1));
    end else if (pick < 55) begin
      if (size_pick < 80)      it.payload_length = 7'($urandom_range(6));
      else if (size_pick < 92) it.payload_length = 7'($urandom_range(MaxPayload, 7));
      else if (size_pick < 95) it.payload_length = 7'(MaxPayload);
      else                     it.payload_length = 7'($urandom_range(127, MaxPayload + 1));
    end else if (pick < 75) begin
      it.cmd = CmdLocalAt;
    end else if (pick < 93) begin
      it.cmd = CmdRemoteAt;
    end else begin
      it.cmd = 2'($urandom_range(3));
    end
    return it;
  endfunction

  task automatic send_item(input afb_in_t item);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame_bytes(item);
    items_sent++;
  endtask

  task automatic wait_all_bytes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_q.size() != 0);
  endtask

  task automatic write_types(input logic [7:0] tx, input logic [7:0] lat,
                             input logic [7:0] rat);
    logic [7:0] vals[3];
    logic [1:0] idx[3];
    vals = '{tx, lat, rat};
    idx  = '{RegTypeTransmit, RegTypeLocalAt, RegTypeRemoteAt};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        RegTypeTransmit: type_tx_m  = vals[i];
        RegTypeLocalAt:  type_lat_m = vals[i];
        default:         type_rat_m = vals[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(make_item(CmdTransmit, 64'h0, 16'h0, 7'd0, 8'h00));
    send_item(make_item(CmdLocalAt, 64'h0, 16'h0000, 7'd0, 8'h00));
    send_item(make_item(CmdLocalAt, '1, 16'hFFFF, '1, 8'hFF));
    send_item(make_item(CmdRemoteAt, '1, 16'hFFFF, '1, 8'hFF));
    send_item(make_item(CmdRemoteAt, 64'h0, 16'h0000, 7'd0, 8'h00));
    send_item(make_item(CmdUnused, '1, 16'hFFFF, '1, 8'hFF));
    send_item(make_item(CmdTransmit, '1, 16'hFFFF, 7'(MaxPayload + 1), 8'hFF));
    send_item(make_item(CmdTransmit, '1, 16'hFFFF, 7'd127, 8'hFF));
    send_item(make_item(CmdTransmit, 64'h0123_4567_89AB_CDEF, 16'h4142, 7'd3, 8'h11));
    send_item(make_item(CmdLocalAt, '1, 16'h4944, 7'd0, 8'h22));
    send_item(make_item(CmdRemoteAt, '1, 16'h4944, 7'd0, 8'h33));
    send_item(make_item(CmdUnused, '1, 16'hFFFF, '1, 8'h44));
    send_item(make_item(CmdTransmit, 64'h0, 16'h0, '1, 8'h00));
    wait_all_bytes();
    send_item(make_item(CmdTransmit, '1, 16'h0, 7'd0, 8'hFF));
    send_item(make_item(CmdTransmit, 64'h0, 16'h0, 7'd0, 8'hA5));
    send_item(make_item(CmdTransmit, '1, 16'h0, 7'd1, 8'h00));
    send_item(make_item(CmdTransmit, 64'h0, 16'hFFFF, 7'd0, 8'hFF));
  endtask

  task automatic test_type_registers();
    logic [7:0] code;
    for (int pass = 0; pass < 3; pass++) begin
      code = (pass == 0) ? 8'h00 : (pass == 1) ? 8'hFF : 8'h5A;
      wait_all_bytes();
      if (pass == 2) write_types(8'd16, 8'd8, 8'd23);
      else write_types(code, code, code);
      send_item(make_item(CmdTransmit, {$urandom, $urandom}, 16'h0, 7'd2, 8'h00));
      send_item(make_item(CmdTransmit, 64'h0, 16'h0, 7'd0, 8'($urandom)));
      send_item(make_item(CmdTransmit, 64'h0, 16'h0, 7'd0, 8'($urandom)));
      send_item(make_item(CmdLocalAt, 64'h0, 16'($urandom), 7'd0, 8'h00));
      send_item(make_item(CmdRemoteAt, {$urandom, $urandom}, 16'($urandom), 7'd0, 8'h00));
    end
  endtask

  task automatic test_frame_id_wrap();
    afb_in_t it;
    repeat (240) begin
      it = random_item();
      if (!open_m) begin
        it.cmd = 2'($urandom_range(2));
        it.payload_length = 7'd0;
      end
      send_item(it);
    end
  endtask

  task automatic test_random(input int unsigned count);
    wait_all_bytes();
    write_types(8'($urandom), 8'($urandom), 8'($urandom));
    repeat (count) begin
      if ($urandom_range(39) == 0) wait_all_bytes();
      send_item(random_item());
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegTypeTransmit;
    cfg_data_i  <= '0;
    type_tx_m  = 8'd16;
    type_lat_m = 8'd8;
    type_rat_m = 8'd23;
    id_count_m = 8'd0;
    sum_m      = 8'd0;
    open_id_m  = 8'd0;
    left_m     = 7'd0;
    open_m     = 1'b0;
    send_gap_pct = 10;
    recv_gap_pct = 79;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_type_registers();
    test_random(70);

    send_gap_pct = 79;
    recv_gap_pct = 10;
    test_frame_id_wrap();
    test_random(70);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random(70);

    wait_all_bytes();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items and checked %0d frame bytes, %0d of them refusals.",
             items_sent, bytes_checked, refusals_expected);
    $display("Covered all frame kinds, empty and full payloads, refused items, id wrap"
             , " and type codes from 0x00 to 0xFF under both stall patterns.");
    if (fail_count == 0 && frame_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
